// ----- hw/rtl/cbez_pkg.sv -----
// ============================================================================
// Cubic Bezier point evaluator - shared package
// Widths of the fixed ports, configuration register map and the control
// group that steps one pipelined multiplier.
// ============================================================================
package cbez_pkg;

    // Fixed port widths
    localparam int PARAM_T_W  = 16;
    localparam int POINT_W    = 24;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 4;

    // Eight coordinate registers: x0, y0, x1, y1, x2, y2, x3, y3
    localparam int CTRL_IDX_W = 3;
    localparam int NUM_CTRL   = 8;
    localparam logic [CFG_IDX_W-1:0] CTRL_REG_COUNT = CFG_IDX_W'(NUM_CTRL);

    // Operand slice handled by one multiplier cell (plus sign bit)
    localparam int MUL_CHUNK_W = 24;

    // Register stages from input to output
    localparam int PIPE_DEPTH = 7;

    // Load enables for the two register stages of one multiplier
    typedef struct packed {
        logic mul;   // partial product stage
        logic add;   // summing stage
    } mul_en_t;

endpackage

// ----- hw/rtl/cbez_mul.sv -----
// ============================================================================
// Cubic Bezier pipelined multiply-add
// result = mul_a * mul_b + addend, signed A by unsigned B. The A operand is
// cut into slices; slice products are registered, then summed with the
// addend in a second stage.
// ============================================================================
module cbez_mul
    import cbez_pkg::*;
#(
    parameter int A_W = 20,
    parameter int B_W = 16
) (
    input  logic                   aclk,
    input  mul_en_t                en,
    input  logic signed [A_W-1:0]  mul_a,
    input  logic [B_W-1:0]         mul_b,
    input  logic signed [A_W+B_W:0] addend,
    output logic signed [A_W+B_W:0] result
);

    localparam int S_W   = A_W + B_W + 1;
    localparam int CH    = MUL_CHUNK_W;
    localparam int NCH   = (A_W + CH - 1) / CH;
    localparam int EXT_W = NCH * CH;
    localparam int PP_W  = CH + B_W + 1;
    localparam int X_W   = EXT_W + B_W + 1;

    logic signed [EXT_W-1:0] a_ext;
    logic signed [PP_W-1:0]  pp_next [NCH];
    logic signed [PP_W-1:0]  pp_reg  [NCH];
    logic signed [S_W-1:0]   addend_reg;
    logic signed [X_W-1:0]   sum_next;
    logic signed [S_W-1:0]   result_reg;

    assign a_ext = EXT_W'(mul_a);

    // Slice products; only the top slice carries the sign
    always_comb begin
        logic signed [CH:0]   ca;
        logic signed [B_W:0]  cb;
        logic signed [PP_W:0] prod;
        cb = {1'b0, mul_b};
        for (int i = 0; i < NCH; i++) begin
            if (i == NCH - 1) begin
                ca = {a_ext[i*CH + CH - 1], a_ext[i*CH +: CH]};
            end else begin
                ca = {1'b0, a_ext[i*CH +: CH]};
            end
            prod       = ca * cb;
            pp_next[i] = prod[PP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            pp_reg     <= pp_next;
            addend_reg <= addend;
        end
    end

    // Weighted sum of the slice products and the addend
    always_comb begin
        sum_next = X_W'(addend_reg);
        for (int i = 0; i < NCH; i++) begin
            sum_next = sum_next + (X_W'(pp_reg[i]) <<< (i * CH));
        end
    end

    always_ff @(posedge aclk) begin
        if (en.add) begin
            result_reg <= sum_next[S_W-1:0];
        end
    end

    assign result = result_reg;

endmodule

// ----- hw/rtl/cubic_bezier_point_eval.sv -----
// ============================================================================
// Cubic Bezier point evaluator - top level
// Streams curve parameters t and returns the points B(t) of a cubic curve
// whose four control points sit in configuration registers.
// ============================================================================
// Usage:
//   cfg_*   : register writes, index 0..7 = x0, y0, x1, y1, x2, y2, x3, y3.
//             Always ready. Write only while no request is in flight.
//             Indexes above 7 are dropped.
//   s_*     : one request carries param_t, t = param_t / 2^T_FRAC_BITS.
//   m_*     : one result per request, point (x, y) with 8 fraction bits,
//             rounded to nearest, ties toward plus infinity.
// Throughput is one request per cycle while the receiver accepts results:
// the curve is evaluated in Horner form by three multiply-add units in a
// row, each of two register stages, behind an input register. Valid bits
// travel with the data; each stage loads when it is empty or its successor
// loads, so a stalled receiver only holds the filled stages and bubbles
// ahead of it still close up.
// Reset clears all control registers to zero and empties the pipeline.
// ============================================================================
module cubic_bezier_point_eval
    import cbez_pkg::*;
#(
    parameter int T_FRAC_BITS = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_addr,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    // parameter requests
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [PARAM_T_W-1:0]        s_param_t,
    // curve points
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [POINT_W-1:0]   m_point_x,
    output logic signed [POINT_W-1:0]   m_point_y
);

    localparam int T   = T_FRAC_BITS;
    localparam int C   = COORD_BITS;
    localparam int CFW = C + 4;            // Horner coefficients
    localparam int H2W = T + C + 5;        // first partial sum
    localparam int H1W = 2*T + C + 6;      // second partial sum
    localparam int ACW = 3*T + C + 7;      // full sum, scaled by 2^(3T)
    localparam int RND_SHIFT = 3*T - 8;
    localparam logic [3*T-1:0] ROUND_HALF = (3*T)'(1) << (RND_SHIFT - 1);

    // Stage numbers
    localparam int ST_IN   = 1;
    localparam int ST_M1P  = 2;
    localparam int ST_M1S  = 3;
    localparam int ST_M2P  = 4;
    localparam int ST_M2S  = 5;
    localparam int ST_M3P  = 6;
    localparam int ST_M3S  = 7;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] ctrl_reg [NUM_CTRL];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CTRL; i++) begin
                ctrl_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready && (cfg_addr < CTRL_REG_COUNT)) begin
            ctrl_reg[cfg_addr[CTRL_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH+1:1] load;
    logic [PIPE_DEPTH:1]   v_src;
    logic [PIPE_DEPTH:1]   v_next;
    logic [PIPE_DEPTH:1]   v_reg;

    always_comb begin
        load[PIPE_DEPTH+1] = m_ready;
        for (int k = PIPE_DEPTH; k >= 1; k--) begin
            load[k] = !v_reg[k] || load[k+1];
        end
    end

    assign v_src = {v_reg[PIPE_DEPTH-1:1], s_valid};

    always_comb begin
        for (int k = 1; k <= PIPE_DEPTH; k++) begin
            v_next[k] = load[k] ? v_src[k] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = load[ST_IN];
    assign m_valid = v_reg[PIPE_DEPTH];

    // ------------------------------------------------------------------
    // Parameter t, carried alongside the first five stages
    // ------------------------------------------------------------------
    logic [T-1:0] u_next;
    logic [T-1:0] u_reg [ST_IN:ST_M2S];

    generate
        if (T <= PARAM_T_W) begin : g_t_narrow
            assign u_next = s_param_t[T-1:0];
        end else begin : g_t_wide
            assign u_next = {{(T-PARAM_T_W){1'b0}}, s_param_t};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (load[ST_IN]) begin
            u_reg[ST_IN] <= u_next;
        end
        for (int k = ST_IN + 1; k <= ST_M2S; k++) begin
            if (load[k]) begin
                u_reg[k] <= u_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Per axis: coefficients and Horner chain
    //   acc = N^3 P0 + u (N^2 c1 + u (N c2 + u c3)),  N = 2^T
    // ------------------------------------------------------------------
    logic signed [C-1:0]   coord [2][4];
    logic signed [ACW-1:0] acc   [2];

    mul_en_t en1, en2, en3;
    assign en1 = '{mul: load[ST_M1P], add: load[ST_M1S]};
    assign en2 = '{mul: load[ST_M2P], add: load[ST_M2S]};
    assign en3 = '{mul: load[ST_M3P], add: load[ST_M3S]};

    generate
        for (genvar a = 0; a < 2; a++) begin : g_axis
            logic signed [CFW-1:0] e0, e1, e2, e3;
            logic signed [CFW-1:0] d10, s012, c1, c2, c3;
            logic signed [H2W-1:0] add1, h2;
            logic signed [H1W-1:0] add2, h1;
            logic signed [ACW-1:0] add3;

            // Register bits above the coordinate width are ignored;
            // a wider coordinate reads the register zero-extended
            for (genvar i = 0; i < 4; i++) begin : g_coord
                if (C <= CFG_DATA_W) begin : g_narrow
                    assign coord[a][i] = ctrl_reg[2*i+a][C-1:0];
                end else begin : g_wide
                    assign coord[a][i] = {{(C-CFG_DATA_W){1'b0}}, ctrl_reg[2*i+a]};
                end
            end

            assign e0 = CFW'(coord[a][0]);
            assign e1 = CFW'(coord[a][1]);
            assign e2 = CFW'(coord[a][2]);
            assign e3 = CFW'(coord[a][3]);

            // c1 = 3(P1-P0), c2 = 3(P0-2P1+P2), c3 = P3-3P2+3P1-P0
            assign d10  = e1 - e0;
            assign s012 = e0 - (e1 <<< 1) + e2;
            assign c1   = (d10 <<< 1) + d10;
            assign c2   = (s012 <<< 1) + s012;
            assign c3   = e3 - ((e2 - e1) <<< 1) - (e2 - e1) - e0;

            assign add1 = {c2[CFW-1], c2, {T{1'b0}}};
            assign add2 = {{2{c1[CFW-1]}}, c1, {(2*T){1'b0}}};
            assign add3 = {{7{coord[a][0][C-1]}}, coord[a][0], ROUND_HALF};

            cbez_mul #(.A_W(CFW), .B_W(T)) u_mul1 (
                .aclk   (aclk),
                .en     (en1),
                .mul_a  (c3),
                .mul_b  (u_reg[ST_IN]),
                .addend (add1),
                .result (h2)
            );

            cbez_mul #(.A_W(H2W), .B_W(T)) u_mul2 (
                .aclk   (aclk),
                .en     (en2),
                .mul_a  (h2),
                .mul_b  (u_reg[ST_M1S]),
                .addend (add2),
                .result (h1)
            );

            cbez_mul #(.A_W(H1W), .B_W(T)) u_mul3 (
                .aclk   (aclk),
                .en     (en3),
                .mul_a  (h1),
                .mul_b  (u_reg[ST_M2S]),
                .addend (add3),
                .result (acc[a])
            );
        end
    endgenerate

    // Rounding half is already in the sum; drop the fraction bits
    assign m_point_x = acc[0][RND_SHIFT + POINT_W - 1 : RND_SHIFT];
    assign m_point_y = acc[1][RND_SHIFT + POINT_W - 1 : RND_SHIFT];

`ifndef SYNTHESIS
    // Empty output stage means the whole chain can load
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    // A ready receiver never stalls the input
    a_ready_follows_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while receiver is ready");

    // Requests in flight are conserved
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ($countones(v_reg) == $past($countones(v_reg))
                  + ($past(s_valid && s_ready) ? 1 : 0)
                  - ($past(m_valid && m_ready) ? 1 : 0)))
        else $error("request lost or duplicated in pipeline");

    // The filled summing stage of the first multiply-add keeps its request while it cannot load
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[ST_M1S] && !load[ST_M1S]) |=> v_reg[ST_M1S])
        else $error("stalled stage dropped its request");
`endif

endmodule
